// ----- rtl/core/gdc_pkg.sv -----
// Shared types and constants of the geometric delay calculator.
`default_nettype none
package gdc_pkg;

  // Length word ahead of the delay conversion, and the delay word itself.
  localparam int LEN_W   = 44;
  localparam int DELAY_W = 45;

  // Longest length that is converted: 2^43 units of 2^-16 m.
  localparam logic [LEN_W-1:0] LEN_CLAMP = 44'h800_0000_0000;

  // Nanoseconds per metre in Q32 (about 2^32 * 1e9 / c).
  localparam logic [LEN_W-1:0] NS_PER_M_Q32 = 44'd14326468800;

  // Saturation limits of the delay magnitude.
  localparam logic [DELAY_W:0] DELAY_LIM     = 46'h1000_0000_0000;
  localparam logic [DELAY_W:0] DELAY_MAX_POS = 46'h0FFF_FFFF_FFFF;

  // Side information that travels beside the divider row.
  typedef struct packed {
    logic             err;
    logic             neg;
    logic             ovf;
    logic [LEN_W-1:0] len_near;
  } side_t;

  // Sign and error flag that travel beside the conversion multiplier.
  typedef struct packed {
    logic err;
    logic neg;
  } sign_t;

  // One finished result word.
  typedef struct packed {
    logic [DELAY_W-1:0] delay;
    logic               err;
  } res_t;

endpackage
`default_nettype wire

// ----- rtl/core/gdc_mult.sv -----
// Two-stage unsigned multiplier built from four half-width partial products.
`default_nettype none
module gdc_mult #(
  parameter int W = 33
) (
  input  wire           clk,
  input  wire           en,
  input  wire [W-1:0]   a,
  input  wire [W-1:0]   b,
  output logic [2*W-1:0] p
);

  localparam int LO_W = (W + 1) / 2;
  localparam int HI_W = W - LO_W;
  localparam int PW   = 2 * W;

  logic [2*LO_W-1:0] ll_r;
  logic [W-1:0]      lh_r;
  logic [W-1:0]      hl_r;
  logic [2*HI_W-1:0] hh_r;
  logic [PW-1:0]     p_r;
  logic [PW-1:0]     p_nxt;

  // Recombine the partial products.
  always_comb begin
    p_nxt = {hh_r, ll_r} + (PW'(lh_r) << LO_W) + (PW'(hl_r) << LO_W);
  end

  // First stage holds the partial products, second stage the full product.
  always_ff @(posedge clk) begin
    if (en) begin
      ll_r <= a[LO_W-1:0] * b[LO_W-1:0];
      lh_r <= a[LO_W-1:0] * b[W-1:LO_W];
      hl_r <= a[W-1:LO_W] * b[LO_W-1:0];
      hh_r <= a[W-1:LO_W] * b[W-1:LO_W];
      p_r  <= p_nxt;
    end
  end

  assign p = p_r;

endmodule
`default_nettype wire

// ----- rtl/core/gdc_sqrt_cell.sv -----
// One cell of the square-root row: settles one bit of the root.
`default_nettype none
module gdc_sqrt_cell #(
  parameter int RW = 41
) (
  input  wire              clk,
  input  wire              en,
  input  wire [2*RW-1:0]   rad_i,
  input  wire [RW-1:0]     rem_i,
  input  wire [RW-1:0]     root_i,
  output logic [2*RW-1:0]  rad_o,
  output logic [RW-1:0]    rem_o,
  output logic [RW-1:0]    root_o
);

  logic [RW+1:0]   t;
  logic [RW+1:0]   trial;
  logic            ge;
  logic [2*RW-1:0] rad_r;
  logic [RW-1:0]   rem_r;
  logic [RW-1:0]   root_r;
  logic [2*RW-1:0] rad_nxt;
  logic [RW-1:0]   rem_nxt;
  logic [RW-1:0]   root_nxt;

  // Bring down two radicand bits and try the next root bit.
  always_comb begin
    t        = {rem_i, rad_i[2*RW-1 -: 2]};
    trial    = {root_i, 2'b01};
    ge       = (t >= trial);
    rem_nxt  = ge ? RW'(t - trial) : RW'(t);
    root_nxt = {root_i[RW-2:0], ge};
    rad_nxt  = {rad_i[2*RW-3:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r  <= rad_nxt;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  assign rad_o  = rad_r;
  assign rem_o  = rem_r;
  assign root_o = root_r;

endmodule
`default_nettype wire

// ----- rtl/core/gdc_div_cell.sv -----
// One cell of the divider row: settles one quotient bit by restoring division.
`default_nettype none
module gdc_div_cell #(
  parameter int RW = 41
) (
  input  wire                         clk,
  input  wire                         en,
  input  wire [RW-1:0]                rem_i,
  input  wire [gdc_pkg::LEN_W-1:0]    bits_i,
  input  wire [RW-1:0]                dvs_i,
  output logic [RW-1:0]               rem_o,
  output logic [gdc_pkg::LEN_W-1:0]   bits_o,
  output logic [RW-1:0]               dvs_o
);

  logic [RW:0]                 t;
  logic [RW:0]                 diff;
  logic                        ge;
  logic [RW-1:0]               rem_r;
  logic [RW-1:0]               rem_nxt;
  logic [gdc_pkg::LEN_W-1:0]   bits_r;
  logic [gdc_pkg::LEN_W-1:0]   bits_nxt;
  logic [RW-1:0]               dvs_r;

  // Shift in the next dividend bit; the quotient bit fills the freed place.
  always_comb begin
    t        = {rem_i, bits_i[gdc_pkg::LEN_W-1]};
    diff     = t - {1'b0, dvs_i};
    ge       = (t >= {1'b0, dvs_i});
    rem_nxt  = ge ? diff[RW-1:0] : t[RW-1:0];
    bits_nxt = {bits_i[gdc_pkg::LEN_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      bits_r <= bits_nxt;
      dvs_r  <= dvs_i;
    end
  end

  assign rem_o  = rem_r;
  assign bits_o = bits_r;
  assign dvs_o  = dvs_r;

endmodule
`default_nettype wire

// ----- rtl/core/geometric_delay_calc_top.sv -----
// Geometric delay calculator: squares, square-root rows, divider row, conversion.
// Throughput: one word per cycle while the output buffer has room; the root rows
// (41 cells at 32) and the 44-cell divider row are fully pipelined, so the rate is
// set by the two-entry output buffer and its consumer only.
// The pipeline stalls as a whole only while both output buffer entries are full.
// Reset clears the pipeline valid bits, empties the output buffer and selects near field.
`default_nettype none
module geometric_delay_calc_top #(
  parameter int COORD_WIDTH = 32
) (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          in_tvalid,
  output logic         in_tready,
  // ant_x, ant_y, ant_z, sky_x, sky_y, sky_z, 32 bits each from bit 0 up
  input  wire [191:0]  in_tdata,
  output logic         out_tvalid,
  input  wire          out_tready,
  // delay (45 bits), then 3 zero bits
  output logic [47:0]  out_tdata,
  // error
  output logic [0:0]   out_tuser,
  input  wire          cfg_valid,
  output logic         cfg_ready,
  input  wire [0:0]    cfg_data
);

  localparam int CW   = COORD_WIDTH;
  localparam int MW   = CW + 1;
  localparam int SQW  = 2 * MW;
  localparam int RW   = MW + 8;
  localparam int PSW  = SQW + 2;
  localparam int PMW  = PSW - 1;
  localparam int QB   = gdc_pkg::LEN_W;
  localparam int NUMW = PMW + 17;
  localparam int HIW  = NUMW - QB;
  localparam int CMPW = (HIW > RW) ? HIW : RW;
  localparam int CLW  = (RW > QB) ? RW : QB;
  localparam int LAT  = RW + QB + 8;
  localparam int DW   = gdc_pkg::DELAY_W;
  localparam logic [2*QB-1:0] ROUND_HALF = (2*QB)'(64'h8000_0000);

  // Handshake and control
  logic            en;
  logic            push;
  logic            pop;
  logic            ff_r;
  logic [LAT-1:0]  vld_r;
  logic [1:0]      cnt_r;
  logic [1:0]      cnt_nxt;

  assign en        = (cnt_r != 2'd2);
  assign in_tready = en;
  assign cfg_ready = 1'b1;
  assign push      = en && vld_r[LAT-1];
  assign pop       = out_tvalid && out_tready;

  // Mode register, pipeline valid line and output buffer count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ff_r  <= 1'b0;
      vld_r <= '0;
      cnt_r <= 2'd0;
    end else begin
      if (cfg_valid) begin
        ff_r <= cfg_data[0];
      end
      if (en) begin
        vld_r <= {vld_r[LAT-2:0], in_tvalid};
      end
      cnt_r <= cnt_nxt;
    end
  end

  // Input stage: coordinates, difference vector, magnitudes and product signs.
  logic signed [CW-1:0] crd [6];
  logic [CW+31:0]       ext [6];
  logic signed [MW-1:0] dd [3];
  logic signed [MW-1:0] se [3];
  logic signed [MW-1:0] ae [3];
  logic [MW-1:0]        md_nxt [3];
  logic [MW-1:0]        ms_nxt [3];
  logic [MW-1:0]        ma_nxt [3];
  logic [2:0]           sg_nxt;
  logic [MW-1:0]        md_r [3];
  logic [MW-1:0]        ms_r [3];
  logic [MW-1:0]        ma_r [3];
  logic [2:0]           sg_r;
  logic [2:0]           sg_d1_r;
  logic [2:0]           sg_d2_r;

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      ext[i] = {{CW{1'b0}}, in_tdata[32*i +: 32]};
      crd[i] = ext[i][CW-1:0];
    end
    for (int k = 0; k < 3; k++) begin
      se[k]     = MW'(crd[k+3]);
      ae[k]     = MW'(crd[k]);
      dd[k]     = se[k] - ae[k];
      md_nxt[k] = dd[k][MW-1] ? MW'(-dd[k]) : MW'(dd[k]);
      ms_nxt[k] = se[k][MW-1] ? MW'(-se[k]) : MW'(se[k]);
      ma_nxt[k] = ae[k][MW-1] ? MW'(-ae[k]) : MW'(ae[k]);
      sg_nxt[k] = se[k][MW-1] ^ ae[k][MW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      md_r    <= md_nxt;
      ms_r    <= ms_nxt;
      ma_r    <= ma_nxt;
      sg_r    <= sg_nxt;
      sg_d1_r <= sg_r;
      sg_d2_r <= sg_d1_r;
    end
  end

  // Squares of the difference and sky vectors, and the dot-product terms.
  logic [SQW-1:0] sqd [3];
  logic [SQW-1:0] sqs [3];
  logic [SQW-1:0] prd [3];

  for (genvar k = 0; k < 3; k++) begin : g_mul
    gdc_mult #(.W(MW)) u_sq_d (
      .clk(clk), .en(en), .a(md_r[k]), .b(md_r[k]), .p(sqd[k])
    );
    gdc_mult #(.W(MW)) u_sq_s (
      .clk(clk), .en(en), .a(ms_r[k]), .b(ms_r[k]), .p(sqs[k])
    );
    gdc_mult #(.W(MW)) u_dot (
      .clk(clk), .en(en), .a(ms_r[k]), .b(ma_r[k]), .p(prd[k])
    );
  end

  // Sums of squares and the signed dot product.
  logic [SQW-1:0]        sumd_r;
  logic [SQW-1:0]        sums_r;
  logic signed [PSW-1:0] p_r;
  logic signed [PSW-1:0] p_nxt;

  always_comb begin
    p_nxt = '0;
    for (int k = 0; k < 3; k++) begin
      if (sg_d2_r[k]) begin
        p_nxt = p_nxt - PSW'(prd[k]);
      end else begin
        p_nxt = p_nxt + PSW'(prd[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sumd_r <= sqd[0] + sqd[1] + sqd[2];
      sums_r <= sqs[0] + sqs[1] + sqs[2];
      p_r    <= p_nxt;
    end
  end

  // Two square-root rows, one root bit per cell.
  logic [2*RW-1:0] rad_d_w  [RW+1];
  logic [RW-1:0]   rem_d_w  [RW+1];
  logic [RW-1:0]   root_d_w [RW+1];
  logic [2*RW-1:0] rad_s_w  [RW+1];
  logic [RW-1:0]   rem_s_w  [RW+1];
  logic [RW-1:0]   root_s_w [RW+1];

  assign rad_d_w[0]  = {sumd_r, 16'h0000};
  assign rem_d_w[0]  = '0;
  assign root_d_w[0] = '0;
  assign rad_s_w[0]  = {sums_r, 16'h0000};
  assign rem_s_w[0]  = '0;
  assign root_s_w[0] = '0;

  for (genvar i = 0; i < RW; i++) begin : g_sqrt
    gdc_sqrt_cell #(.RW(RW)) u_cell_d (
      .clk(clk), .en(en),
      .rad_i(rad_d_w[i]), .rem_i(rem_d_w[i]), .root_i(root_d_w[i]),
      .rad_o(rad_d_w[i+1]), .rem_o(rem_d_w[i+1]), .root_o(root_d_w[i+1])
    );
    gdc_sqrt_cell #(.RW(RW)) u_cell_s (
      .clk(clk), .en(en),
      .rad_i(rad_s_w[i]), .rem_i(rem_s_w[i]), .root_i(root_s_w[i]),
      .rad_o(rad_s_w[i+1]), .rem_o(rem_s_w[i+1]), .root_o(root_s_w[i+1])
    );
  end

  // The dot product waits beside the root rows.
  logic signed [PSW-1:0] p_dly_r [RW];

  always_ff @(posedge clk) begin
    if (en) begin
      p_dly_r[0] <= p_r;
      for (int i = 1; i < RW; i++) begin
        p_dly_r[i] <= p_dly_r[i-1];
      end
    end
  end

  // Dividend set-up for far field, difference of norms for near field.
  logic [RW-1:0]         nd;
  logic [RW-1:0]         ns;
  logic signed [PSW-1:0] p_at;
  logic [PMW-1:0]        pmag;
  logic [NUMW-1:0]       num;
  logic [HIW-1:0]        nhi;
  logic                  dneg;
  logic [RW-1:0]         dmag;
  gdc_pkg::side_t        side_nxt;
  logic [RW-1:0]         rem0_r;
  logic [QB-1:0]         numlo_r;
  logic [RW-1:0]         nsc_r;
  gdc_pkg::side_t        side_c_r;

  always_comb begin
    nd   = root_d_w[RW];
    ns   = root_s_w[RW];
    p_at = p_dly_r[RW-1];
    pmag = p_at[PSW-1] ? PMW'(-p_at) : PMW'(p_at);
    num  = NUMW'({pmag, 16'h0000}) + NUMW'(ns >> 1);
    nhi  = num[NUMW-1:QB];
    dneg = (nd < ns);
    dmag = dneg ? (ns - nd) : (nd - ns);
    side_nxt.err = ff_r && (ns == '0);
    side_nxt.neg = ff_r ? (!p_at[PSW-1] && (p_at != '0)) : dneg;
    side_nxt.ovf = (CMPW'(nhi) >= CMPW'(ns));
    side_nxt.len_near = (CLW'(dmag) > CLW'(gdc_pkg::LEN_CLAMP)) ?
                        gdc_pkg::LEN_CLAMP : QB'(dmag);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem0_r   <= RW'(CMPW'(nhi));
      numlo_r  <= num[QB-1:0];
      nsc_r    <= ns;
      side_c_r <= side_nxt;
    end
  end

  // Divider row, one quotient bit per cell.
  logic [RW-1:0] rem_q_w [QB+1];
  logic [QB-1:0] bits_w  [QB+1];
  logic [RW-1:0] dvs_w   [QB+1];

  assign rem_q_w[0] = rem0_r;
  assign bits_w[0]  = numlo_r;
  assign dvs_w[0]   = nsc_r;

  for (genvar i = 0; i < QB; i++) begin : g_div
    gdc_div_cell #(.RW(RW)) u_cell (
      .clk(clk), .en(en),
      .rem_i(rem_q_w[i]), .bits_i(bits_w[i]), .dvs_i(dvs_w[i]),
      .rem_o(rem_q_w[i+1]), .bits_o(bits_w[i+1]), .dvs_o(dvs_w[i+1])
    );
  end

  // Side information waits beside the divider row.
  gdc_pkg::side_t side_dly_r [QB];

  always_ff @(posedge clk) begin
    if (en) begin
      side_dly_r[0] <= side_c_r;
      for (int i = 1; i < QB; i++) begin
        side_dly_r[i] <= side_dly_r[i-1];
      end
    end
  end

  // Length selection with clamping.
  gdc_pkg::side_t side_at;
  logic [QB-1:0]  q;
  logic [QB-1:0]  far_len;
  logic [QB-1:0]  len_r;
  gdc_pkg::sign_t sgn_nxt;
  gdc_pkg::sign_t sgn_d_r;
  gdc_pkg::sign_t sgn_e1_r;
  gdc_pkg::sign_t sgn_e2_r;

  always_comb begin
    side_at     = side_dly_r[QB-1];
    q           = bits_w[QB];
    far_len     = (side_at.ovf || (q > gdc_pkg::LEN_CLAMP)) ? gdc_pkg::LEN_CLAMP : q;
    sgn_nxt.err = side_at.err;
    sgn_nxt.neg = side_at.neg;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      len_r    <= ff_r ? far_len : side_at.len_near;
      sgn_d_r  <= sgn_nxt;
      sgn_e1_r <= sgn_d_r;
      sgn_e2_r <= sgn_e1_r;
    end
  end

  // Length to delay: multiply by ns per metre in Q32.
  logic [2*QB-1:0] prodk;

  gdc_mult #(.W(QB)) u_conv (
    .clk(clk), .en(en), .a(len_r), .b(gdc_pkg::NS_PER_M_Q32), .p(prodk)
  );

  // Rounding, saturation and sign.
  logic [2*QB-1:0] mfull;
  logic [DW:0]     mag;
  logic [DW:0]     sat;
  logic [DW:0]     negv;
  gdc_pkg::res_t   res_nxt;

  always_comb begin
    mfull = prodk + ROUND_HALF;
    mag   = mfull[DW+32:32];
    if (sgn_e2_r.neg) begin
      sat  = (mag > gdc_pkg::DELAY_LIM) ? gdc_pkg::DELAY_LIM : mag;
      negv = (DW+1)'(0) - sat;
    end else begin
      sat  = (mag > gdc_pkg::DELAY_MAX_POS) ? gdc_pkg::DELAY_MAX_POS : mag;
      negv = sat;
    end
    res_nxt.delay = sgn_e2_r.err ? '0 : negv[DW-1:0];
    res_nxt.err   = sgn_e2_r.err;
  end

  // Two-entry output buffer; the head entry drives the result port.
  gdc_pkg::res_t buf0_r;
  gdc_pkg::res_t buf1_r;
  gdc_pkg::res_t buf0_nxt;
  gdc_pkg::res_t buf1_nxt;

  always_comb begin
    buf0_nxt = buf0_r;
    buf1_nxt = buf1_r;
    cnt_nxt  = cnt_r;
    if (push && pop) begin
      if (cnt_r == 2'd1) begin
        buf0_nxt = res_nxt;
      end else begin
        buf0_nxt = buf1_r;
        buf1_nxt = res_nxt;
      end
    end else if (push) begin
      if (cnt_r == 2'd0) begin
        buf0_nxt = res_nxt;
      end else begin
        buf1_nxt = res_nxt;
      end
      cnt_nxt = 2'(cnt_r + 2'd1);
    end else if (pop) begin
      buf0_nxt = buf1_r;
      cnt_nxt  = 2'(cnt_r - 2'd1);
    end
  end

  always_ff @(posedge clk) begin
    buf0_r <= buf0_nxt;
    buf1_r <= buf1_nxt;
  end

  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tdata  = {3'b000, buf0_r.delay};
  assign out_tuser  = buf0_r.err;

endmodule
`default_nettype wire
